@@ hw/rtl/lsts_pkg.sv @@
// Package for the least-slack task scheduler: opcodes, result kinds, sizes, 34-bit clamp.
// No dependencies.
package lsts_pkg;
  localparam int MaxTasks = 32;
  localparam int MaxReady = 16;
  localparam int TIdxW = $clog2(MaxTasks);
  localparam int RIdxW = $clog2(MaxReady);
  localparam int TCntW = $clog2(MaxTasks + 1);
  localparam int RCntW = $clog2(MaxReady + 1);

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_SCHEDULE = 2'd2;
  localparam logic [1:0] OP_RETIRE   = 2'd3;

  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_DROP    = 3'd1;
  localparam logic [2:0] KIND_RUN     = 3'd2;
  localparam logic [2:0] KIND_SERVER  = 3'd3;
  localparam logic [2:0] KIND_IDLE    = 3'd4;

  localparam logic signed [35:0] S34_MAX = 36'sd8589934591;
  localparam logic signed [35:0] S34_MIN = -36'sd8589934592;

  // Clamp a 36-bit signed value into the 34-bit signed range.
  function automatic logic signed [33:0] sat34(input logic signed [35:0] v);
    logic signed [35:0] c;
    begin
      c = v;
      if (v > S34_MAX) c = S34_MAX;
      if (v < S34_MIN) c = S34_MIN;
      sat34 = c[33:0];
    end
  endfunction
endpackage

@@ hw/rtl/lsts_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Uses lsts_pkg only for house consistency of imports.
module lsts_div
  import lsts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[63]} - {1'b0, divisor};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

@@ hw/rtl/least_slack_task_scheduler_top.sv @@
// Top level of the least-slack task scheduler: task table, ready set, sequencer.
// Depends on lsts_pkg and lsts_div.
//
// Usage: one input item carries an opcode and its operands on the in_ ports
// (in_valid / in_stall). Register, release and retire each answer one
// acknowledge item. Schedule answers zero or more drop items followed by one
// run-task, run-server or idle item; out_last marks the final item.
// Retire scans the ready set and compacts it when it finds the task.
// Schedule walks the ready set once per drop and then, for every ready
// job, every table entry; each entry that contributes a share goes
// through the shared bit-serial divider, so a schedule request takes
// longer the more shares apply. The block accepts no new item until the
// last result of the current one has been taken. Reset empties the table
// and the ready set. When the receiver stalls, the result item holds and
// the sequencer waits.
module least_slack_task_scheduler_top
  import lsts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_task_id,
  input  logic [31:0]        in_arrival_time,
  input  logic [31:0]        in_deadline_time,
  input  logic [31:0]        in_budget_time,
  input  logic [31:0]        in_real_time,
  input  logic [31:0]        in_now_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_job_id,
  output logic signed [33:0] out_slack_value,
  output logic signed [33:0] out_end_time,
  output logic               out_last
);
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_EMIT   = 4'd2;
  localparam logic [3:0] ST_SHIFT  = 4'd3;
  localparam logic [3:0] ST_FIND   = 4'd4;
  localparam logic [3:0] ST_EDF    = 4'd5;
  localparam logic [3:0] ST_JOB    = 4'd6;
  localparam logic [3:0] ST_TAB    = 4'd7;
  localparam logic [3:0] ST_DIVW   = 4'd8;
  localparam logic [3:0] ST_JEND   = 4'd9;
  localparam logic [3:0] ST_DECIDE = 4'd10;
  localparam logic [3:0] ST_EDFCHK = 4'd11;
  localparam logic [3:0] ST_RDJ    = 4'd12;

  // Storage.
  logic [7:0]  tid_m  [MaxTasks];
  logic [31:0] tarr_m [MaxTasks];
  logic [31:0] tdl_m  [MaxTasks];
  logic [7:0]  rid_m  [MaxReady];
  logic [31:0] rarr_m [MaxReady];
  logic [31:0] rdl_m  [MaxReady];
  logic [31:0] rbud_m [MaxReady];
  logic [31:0] rreal_m[MaxReady];

  logic [TCntW-1:0] tcnt_r;
  logic [RCntW-1:0] rcnt_r;
  logic [3:0]  st_r;
  logic [1:0]  op_r;
  logic [7:0]  id_r;
  logic [31:0] arr_r, dl_r, bud_r, real_r, now_r;
  logic [RCntW-1:0] i_r;     // ready scan index
  logic [TCntW-1:0] t_r;     // table scan index
  logic [RIdxW-1:0] e_r;     // earliest-deadline slot
  logic [31:0] edl_r;
  logic signed [33:0] s_r, best_s_r;
  logic [RIdxW-1:0] best_r;
  logic        neg_r;
  // Current job operands.
  logic [7:0]  jid_r;
  logic [31:0] jarr_r, jdl_r, jbud_r;
  // Output register.
  logic        ov_r;
  logic [2:0]  ok_r;
  logic [7:0]  oid_r;
  logic signed [33:0] os_r, oe_r;
  logic        ol_r;
  logic [3:0]  ret_r;

  logic        div_start, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic [31:0] ta, td, amax;

  lsts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  assign in_stall = (st_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_job_id = oid_r;
  assign out_slack_value = os_r;
  assign out_end_time = oe_r;
  assign out_last = ol_r;

  // Table entry under the scan pointer.
  assign ta = tarr_m[t_r[TIdxW-1:0]];
  assign td = tdl_m[t_r[TIdxW-1:0]];
  assign amax = (ta > jarr_r) ? ta : jarr_r;
  assign div_dvs = td - ta;
  assign div_dvd = (amax <= jdl_r) ? 64'(jbud_r) * 64'(jdl_r - amax)
                                   : 64'(jbud_r) * 64'(amax - jdl_r);

  // Sequencer.
  always_ff @(posedge clk) begin
    logic signed [63:0] acc;
    logic [63:0] qc;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      tcnt_r <= '0;
      rcnt_r <= '0;
      ov_r <= 1'b0;
      div_start <= 1'b0;
      ret_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r <= in_opcode;
            id_r <= in_task_id;
            arr_r <= in_arrival_time;
            dl_r <= in_deadline_time;
            bud_r <= in_budget_time;
            real_r <= in_real_time;
            now_r <= in_now_time;
            st_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          ok_r <= KIND_ACK;
          oid_r <= '0;
          os_r <= '0;
          oe_r <= '0;
          ol_r <= 1'b1;
          unique case (op_r)
            OP_REGISTER: begin
              if (tcnt_r < TCntW'(MaxTasks)) begin
                tid_m[tcnt_r[TIdxW-1:0]] <= id_r;
                tarr_m[tcnt_r[TIdxW-1:0]] <= arr_r;
                tdl_m[tcnt_r[TIdxW-1:0]] <= dl_r;
                tcnt_r <= tcnt_r + 1'b1;
              end
              ov_r <= 1'b1;
              ret_r <= ST_IDLE;
              st_r <= ST_EMIT;
            end
            OP_RELEASE: begin
              if (rcnt_r < RCntW'(MaxReady)) begin
                rid_m[rcnt_r[RIdxW-1:0]] <= id_r;
                rarr_m[rcnt_r[RIdxW-1:0]] <= arr_r;
                rdl_m[rcnt_r[RIdxW-1:0]] <= dl_r;
                rbud_m[rcnt_r[RIdxW-1:0]] <= bud_r;
                rreal_m[rcnt_r[RIdxW-1:0]] <= real_r;
                rcnt_r <= rcnt_r + 1'b1;
              end
              ov_r <= 1'b1;
              ret_r <= ST_IDLE;
              st_r <= ST_EMIT;
            end
            OP_RETIRE: begin
              i_r <= '0;
              st_r <= ST_FIND;
            end
            default: begin
              i_r <= RCntW'(1);
              e_r <= '0;
              edl_r <= rdl_m[0];
              st_r <= (rcnt_r == '0) ? ST_DECIDE : ST_EDF;
            end
          endcase
        end
        // Hold the result until the receiver takes it.
        ST_EMIT: begin
          if (!out_stall) begin
            ov_r <= 1'b0;
            st_r <= ret_r;
          end
        end
        // Retire: look for the first matching slot.
        ST_FIND: begin
          if (i_r >= rcnt_r) begin
            ov_r <= 1'b1;
            ret_r <= ST_IDLE;
            st_r <= ST_EMIT;
          end else if (rid_m[i_r[RIdxW-1:0]] == id_r) begin
            st_r <= ST_SHIFT;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        // Close the gap one slot per cycle, keeping order.
        ST_SHIFT: begin
          if (i_r + 1'b1 < rcnt_r) begin
            rid_m[i_r[RIdxW-1:0]] <= rid_m[RIdxW'(i_r + 1'b1)];
            rarr_m[i_r[RIdxW-1:0]] <= rarr_m[RIdxW'(i_r + 1'b1)];
            rdl_m[i_r[RIdxW-1:0]] <= rdl_m[RIdxW'(i_r + 1'b1)];
            rbud_m[i_r[RIdxW-1:0]] <= rbud_m[RIdxW'(i_r + 1'b1)];
            rreal_m[i_r[RIdxW-1:0]] <= rreal_m[RIdxW'(i_r + 1'b1)];
            i_r <= i_r + 1'b1;
          end else begin
            rcnt_r <= rcnt_r - 1'b1;
            if (op_r == OP_RETIRE) begin
              ov_r <= 1'b1;
              ret_r <= ST_IDLE;
              st_r <= ST_EMIT;
            end else begin
              i_r <= RCntW'(1);
              e_r <= '0;
              edl_r <= rdl_m[0];
              st_r <= (rcnt_r == RCntW'(1)) ? ST_DECIDE : ST_EDF;
            end
          end
        end
        // Earliest-deadline search, one slot per cycle.
        ST_EDF: begin
          if (i_r >= rcnt_r) begin
            st_r <= ST_EDFCHK;
          end else begin
            if (rdl_m[i_r[RIdxW-1:0]] < edl_r) begin
              edl_r <= rdl_m[i_r[RIdxW-1:0]];
              e_r <= i_r[RIdxW-1:0];
            end
            i_r <= i_r + 1'b1;
          end
        end
        // Drop the earliest job if it cannot finish in time.
        ST_EDFCHK: begin
          if (33'(edl_r) < 33'(rreal_m[e_r]) + 33'(now_r)) begin
            ok_r <= KIND_DROP;
            oid_r <= rid_m[e_r];
            os_r <= '0;
            oe_r <= '0;
            ol_r <= 1'b0;
            ov_r <= 1'b1;
            i_r <= RCntW'(e_r);
            ret_r <= ST_SHIFT;
            st_r <= ST_EMIT;
          end else begin
            i_r <= '0;
            st_r <= ST_RDJ;
          end
        end
        // Load the next job for the slack pass.
        ST_RDJ: begin
          jid_r <= rid_m[i_r[RIdxW-1:0]];
          jarr_r <= rarr_m[i_r[RIdxW-1:0]];
          jdl_r <= rdl_m[i_r[RIdxW-1:0]];
          jbud_r <= rbud_m[i_r[RIdxW-1:0]];
          s_r <= sat34(36'(rdl_m[i_r[RIdxW-1:0]]) - 36'(now_r)
                       - 36'(rbud_m[i_r[RIdxW-1:0]]));
          t_r <= '0;
          st_r <= ST_TAB;
        end
        // Walk the table; start a division for each contributing entry.
        ST_TAB: begin
          if (t_r >= tcnt_r) begin
            st_r <= ST_JEND;
          end else if (tid_m[t_r[TIdxW-1:0]] == jid_r || ta > jdl_r || td <= jdl_r) begin
            t_r <= t_r + 1'b1;
          end else begin
            neg_r <= (amax > jdl_r);
            div_start <= 1'b1;
            st_r <= ST_DIVW;
          end
        end
        // Apply the share: a subtracted share wraps in 64 bits, an added one
        // is capped first; the sum is then clamped to 34 bits.
        ST_DIVW: begin
          div_start <= 1'b0;
          if (div_done) begin
            qc = div_q;
            if (neg_r) begin
              if (qc > 64'h4_0000_0000) qc = 64'h4_0000_0000;
              acc = 64'(s_r) + $signed(qc);
            end else begin
              acc = 64'(s_r) - $signed(qc);
            end
            if (acc > 64'(S34_MAX)) s_r <= S34_MAX[33:0];
            else if (acc < 64'(S34_MIN)) s_r <= S34_MIN[33:0];
            else s_r <= acc[33:0];
            t_r <= t_r + 1'b1;
            st_r <= ST_TAB;
          end
        end
        ST_JEND: begin
          if (i_r == '0 || s_r < best_s_r) begin
            best_s_r <= s_r;
            best_r <= i_r[RIdxW-1:0];
          end
          if (i_r + 1'b1 < rcnt_r) begin
            i_r <= i_r + 1'b1;
            st_r <= ST_RDJ;
          end else begin
            st_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          ol_r <= 1'b1;
          ov_r <= 1'b1;
          ret_r <= ST_IDLE;
          st_r <= ST_EMIT;
          if (rcnt_r == '0) begin
            ok_r <= KIND_IDLE;
            oid_r <= '0;
            os_r <= '0;
            oe_r <= '0;
          end else if (best_s_r == '0) begin
            ok_r <= KIND_RUN;
            oid_r <= rid_m[best_r];
            os_r <= '0;
            oe_r <= 34'(33'(now_r) + 33'(rreal_m[best_r]));
          end else begin
            ok_r <= KIND_SERVER;
            oid_r <= rid_m[best_r];
            os_r <= best_s_r;
            oe_r <= sat34(36'(best_s_r) + 36'(now_r));
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/lsts_checker.sv @@
// Port-level checker for the least-slack task scheduler, bound to the top.
// Depends on lsts_pkg.
module lsts_checker
  import lsts_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic       out_last
);
  // Input is never taken while a result is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // A drop is never the final result.
  a_drop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DROP) |-> !out_last)
    else $error("drop marked last");
  // Final kinds always carry last.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DROP) |-> out_last)
    else $error("final result without last");
  // A stalled result stays valid and keeps its kind.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind)))
    else $error("stalled result changed");
endmodule

bind least_slack_task_scheduler_top lsts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
  .out_last(out_last)
);
